[hw/rtl/svpwm_pkg.sv]
// Shared constants, types and the sine table for the space-vector PWM modulator.
package svpwm_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int DUTY_WIDTH      = 16;
   localparam int TBL_QUARTER     = 1 << (SINE_TABLE_BITS - 2);
   localparam int DUTY_MAX        = (1 << DUTY_WIDTH) - 1;
   localparam int PIPE_DEPTH      = 11;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [2:0] {
      CSR_PWM_GAIN        = 3'd0,
      CSR_PWM_CENTRE      = 3'd1,
      CSR_MODULATION_MODE = 3'd2,
      CSR_SINE_THRESHOLD  = 3'd3,
      CSR_DEADTIME_COUNTS = 3'd4,
      CSR_DEADTIME_ENABLE = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_U    = 2'd0,
      PHASE_V    = 2'd1,
      PHASE_W    = 2'd2,
      PHASE_NONE = 2'd3
   } phase_type;

   typedef logic [14:0] qtr_tbl_type [0:TBL_QUARTER];

   // Quarter-wave sine in Q1.14 from a truncated Taylor series in Q30
   function automatic logic [14:0] quarter_sine(int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      longint r;
      x    = (HALF_PI_Q30 * longint'(k)) / TBL_QUARTER;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum * 16384 + (longint'(1) << 29)) >>> 30;
      if (r > 16384) begin
         r = 16384;
      end
      return r[14:0];
   endfunction

   function automatic qtr_tbl_type build_qtr();
      qtr_tbl_type t;
      for (int k = 0; k <= TBL_QUARTER; k++) begin
         t[k] = quarter_sine(k);
      end
      return t;
   endfunction

   localparam qtr_tbl_type SIN_QTR = build_qtr();

   // Full-turn sine from the quarter wave by symmetry
   function automatic logic signed [15:0] sine_at(logic [SINE_TABLE_BITS-1:0] idx);
      logic [SINE_TABLE_BITS-3:0] r;
      logic [SINE_TABLE_BITS-2:0] mirror;
      logic [14:0] mag;
      r      = idx[SINE_TABLE_BITS-3:0];
      mirror = (SINE_TABLE_BITS-1)'(TBL_QUARTER) - {1'b0, r};
      mag    = idx[SINE_TABLE_BITS-2] ? SIN_QTR[mirror] : SIN_QTR[r];
      return idx[SINE_TABLE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

[hw/rtl/foc_svpwm_modulator.sv]
// Top level: pipelined inverse Park/Clarke with min/max injection and dead-time compensation.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-----------------------------------
//  request | req_* fields                   | taken when start high and busy low
//  result  | rsp_duty_*, rsp_top_phase      | rsp_valid strobe, one cycle, no stall
//  config  | csr_write_enable/index/data    | written with enable high, out of reset
//
// One word enters per cycle while busy is low; each result passes through the eleven
// register stages (table, products, Park, Clarke multiply, phases, min/max,
// difference, split gain multiply, sum, scale, dead-time).
// Reset is synchronous and clears the valid line; busy is a registered copy of reset.
// The receiver cannot stall, so the pipeline never holds.
module foc_svpwm_modulator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_vd_demand,
   input  logic [15:0] req_vq_demand,
   input  logic [15:0] req_vd_offset,
   input  logic [15:0] req_vq_offset,
   input  logic [15:0] req_rotor_angle,
   input  logic [14:0] req_voltage_magnitude,
   input  logic [15:0] req_current_u,
   input  logic [15:0] req_current_v,
   input  logic [15:0] req_current_w,
   output logic        rsp_valid,
   output logic [15:0] rsp_duty_u,
   output logic [15:0] rsp_duty_v,
   output logic [15:0] rsp_duty_w,
   output logic [1:0]  rsp_top_phase,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import svpwm_pkg::*;

   typedef struct packed {
      logic signed [15:0] cu;
      logic signed [15:0] cv;
      logic signed [15:0] cw;
      logic               below;
      logic               mid;
   } side_type;

   localparam logic signed [17:0] SQRT3_HALF = 18'sd56756;

   // configuration registers
   logic [15:0] gain_ff, centre_ff;
   logic        mode_ff, dt_en_ff;
   logic [14:0] thresh_ff;
   logic [7:0]  dt_cnt_ff;
   logic        busy_ff;

   // write configuration
   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         gain_ff   <= 16'd256;
         centre_ff <= '0;
         mode_ff   <= 1'b0;
         thresh_ff <= '0;
         dt_cnt_ff <= '0;
         dt_en_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PWM_GAIN:        gain_ff   <= csr_write_data;
            CSR_PWM_CENTRE:      centre_ff <= csr_write_data;
            CSR_MODULATION_MODE: mode_ff   <= csr_write_data[0];
            CSR_SINE_THRESHOLD:  thresh_ff <= csr_write_data[14:0];
            CSR_DEADTIME_COUNTS: dt_cnt_ff <= csr_write_data[7:0];
            CSR_DEADTIME_ENABLE: dt_en_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign busy = busy_ff;

   // advance valid bits
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], start & ~busy_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // side information travels alongside the data
   side_type side_ff [1:PIPE_DEPTH];
   side_type side_in;
   logic     below_in;
   assign below_in = req_voltage_magnitude < thresh_ff;
   assign side_in  = '{cu: req_current_u, cv: req_current_v, cw: req_current_w,
                       below: below_in, mid: ~mode_ff | below_in};
   always_ff @(posedge clock) begin
      side_ff[1] <= side_in;
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // stage 1: add offsets, look up sine and cosine
   logic signed [16:0] s1_vd_ff, s1_vq_ff;
   logic signed [15:0] s1_sin_ff, s1_cos_ff;
   logic [SINE_TABLE_BITS-1:0] idx_in, cidx_in;
   assign idx_in  = req_rotor_angle[15 -: SINE_TABLE_BITS];
   assign cidx_in = idx_in + SINE_TABLE_BITS'(TBL_QUARTER);
   always_ff @(posedge clock) begin
      s1_vd_ff  <= $signed({req_vd_demand[15], req_vd_demand})
                 + $signed({req_vd_offset[15], req_vd_offset});
      s1_vq_ff  <= $signed({req_vq_demand[15], req_vq_demand})
                 + $signed({req_vq_offset[15], req_vq_offset});
      s1_sin_ff <= sine_at(idx_in);
      s1_cos_ff <= sine_at(cidx_in);
   end

   // stage 2: Park products
   logic signed [32:0] s2_cvd_ff, s2_svq_ff, s2_svd_ff, s2_cvq_ff;
   always_ff @(posedge clock) begin
      s2_cvd_ff <= s1_cos_ff * s1_vd_ff;
      s2_svq_ff <= s1_sin_ff * s1_vq_ff;
      s2_svd_ff <= s1_sin_ff * s1_vd_ff;
      s2_cvq_ff <= s1_cos_ff * s1_vq_ff;
   end

   // stage 3: alpha and beta, rounded half up
   logic signed [33:0] a_sum_in, b_sum_in;
   logic signed [25:0] s3_a_ff, s3_b_ff;
   assign a_sum_in = 34'(s2_cvd_ff) - 34'(s2_svq_ff) + 34'sd128;
   assign b_sum_in = 34'(s2_svd_ff) + 34'(s2_cvq_ff) + 34'sd128;
   always_ff @(posedge clock) begin
      s3_a_ff <= a_sum_in[33:8];
      s3_b_ff <= b_sum_in[33:8];
   end

   // stage 4: scale beta by sqrt(3)/2
   logic signed [43:0] s4_kb_ff;
   logic signed [25:0] s4_a_ff;
   always_ff @(posedge clock) begin
      s4_kb_ff <= s3_b_ff * SQRT3_HALF;
      s4_a_ff  <= s3_a_ff;
   end

   // stage 5: three phase voltages
   logic signed [44:0] half_in;
   logic signed [44:0] s5_ph_ff [3];
   assign half_in = -(45'(s4_a_ff) <<< 15);
   always_ff @(posedge clock) begin
      s5_ph_ff[0] <= 45'(s4_a_ff) <<< 16;
      s5_ph_ff[1] <= half_in + 45'(s4_kb_ff);
      s5_ph_ff[2] <= half_in - 45'(s4_kb_ff);
   end

   // stage 6: highest and lowest phase, earlier phase wins ties
   logic signed [44:0] top_in, bot_in;
   phase_type          tidx_in;
   logic signed [44:0] s6_ph_ff [3];
   logic signed [44:0] s6_top_ff, s6_bot_ff;
   phase_type          tidx_ff [6:PIPE_DEPTH];
   always_comb begin
      top_in  = s5_ph_ff[0];
      bot_in  = s5_ph_ff[0];
      tidx_in = PHASE_U;
      if (s5_ph_ff[1] > top_in) begin
         top_in  = s5_ph_ff[1];
         tidx_in = PHASE_V;
      end
      if (s5_ph_ff[2] > top_in) begin
         top_in  = s5_ph_ff[2];
         tidx_in = PHASE_W;
      end
      if (s5_ph_ff[1] < bot_in) bot_in = s5_ph_ff[1];
      if (s5_ph_ff[2] < bot_in) bot_in = s5_ph_ff[2];
      if (side_ff[5].below) tidx_in = PHASE_NONE;
   end
   always_ff @(posedge clock) begin
      s6_ph_ff   <= s5_ph_ff;
      s6_top_ff  <= top_in;
      s6_bot_ff  <= bot_in;
      tidx_ff[6] <= tidx_in;
      for (int k = 7; k <= PIPE_DEPTH; k++) begin
         tidx_ff[k] <= tidx_ff[k-1];
      end
   end

   // stage 7: distance from the clamp reference
   logic signed [46:0] s7_d_ff [3];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (side_ff[6].mid) begin
            s7_d_ff[i] <= (47'(s6_ph_ff[i]) <<< 1) - 47'(s6_top_ff) - 47'(s6_bot_ff);
         end else begin
            s7_d_ff[i] <= 47'(s6_ph_ff[i]) - 47'(s6_bot_ff);
         end
      end
   end

   // stage 8: gain times distance as two partial products
   logic [39:0]        s8_lo_ff [3];
   logic signed [39:0] s8_hi_ff [3];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s8_lo_ff[i] <= s7_d_ff[i][23:0] * gain_ff;
         s8_hi_ff[i] <= $signed(s7_d_ff[i][46:24]) * $signed({1'b0, gain_ff});
      end
   end

   // stage 9: join partial products
   logic signed [63:0] s9_p_ff [3];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s9_p_ff[i] <= (64'(s8_hi_ff[i]) <<< 24) + $signed({24'd0, s8_lo_ff[i]});
      end
   end

   // stage 10: scale to counts, add centre in midpoint mode, saturate
   logic signed [25:0] sh_in [3];
   logic signed [26:0] q_in [3];
   logic [15:0]        s10_c_ff [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (side_ff[9].mid) begin
            sh_in[i] = $signed(s9_p_ff[i][63:38]) >>> 1;
            q_in[i]  = 27'(sh_in[i]) + $signed({11'd0, centre_ff});
         end else begin
            sh_in[i] = s9_p_ff[i][63:38];
            q_in[i]  = 27'(sh_in[i]);
         end
      end
   end
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (q_in[i] < 0) begin
            s10_c_ff[i] <= '0;
         end else if (q_in[i] > 27'sd0 + DUTY_MAX) begin
            s10_c_ff[i] <= 16'(DUTY_MAX);
         end else begin
            s10_c_ff[i] <= q_in[i][15:0];
         end
      end
   end

   // stage 11: dead-time compensation by current above or below -30 (mode 0, enabled)
   logic signed [15:0] cur_in [3];
   logic signed [17:0] adj_in [3];
   logic [15:0]        out_ff [3];
   assign cur_in[0] = side_ff[10].cu;
   assign cur_in[1] = side_ff[10].cv;
   assign cur_in[2] = side_ff[10].cw;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         adj_in[i] = $signed({2'b00, s10_c_ff[i]});
         if (~mode_ff && dt_en_ff) begin
            if (cur_in[i] < -16'sd30) begin
               adj_in[i] = adj_in[i] - $signed({10'd0, dt_cnt_ff});
            end else if (cur_in[i] > -16'sd30) begin
               adj_in[i] = adj_in[i] + $signed({10'd0, dt_cnt_ff});
            end
         end
      end
   end
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (adj_in[i] < 0) begin
            out_ff[i] <= '0;
         end else if (adj_in[i] > 18'sd0 + DUTY_MAX) begin
            out_ff[i] <= 16'(DUTY_MAX);
         end else begin
            out_ff[i] <= adj_in[i][15:0];
         end
      end
   end

   assign rsp_valid     = vld_ff[PIPE_DEPTH-1];
   assign rsp_duty_u    = out_ff[0];
   assign rsp_duty_v    = out_ff[1];
   assign rsp_duty_w    = out_ff[2];
   assign rsp_top_phase = tidx_ff[PIPE_DEPTH];

endmodule

[hw/rtl/svpwm_checker.sv]
// Port-level checks on the modulator's timing, bound to the top level.
module svpwm_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   import svpwm_pkg::*;

   // every accepted word yields a result strobe later on
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_valid)
      else $error("result strobe missing after accepted word");

   // no strobe without a word accepted at the matching edge
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result strobe without accepted word");

   // reset drops the pipeline
   a_reset_clear : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // busy only follows reset
   a_busy : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy outside reset");

endmodule

bind foc_svpwm_modulator svpwm_checker u_svpwm_checker (.*);

[bench/foc_svpwm_modulator_test.sv]
// Testbench for the space-vector PWM modulator: random and directed words against a predictor.
`timescale 1ns / 100ps

module foc_svpwm_modulator_test;
   import svpwm_pkg::*;

   typedef struct {
      logic [15:0] vd, vq, vdo, vqo, angle;
      logic [14:0] mag;
      logic [15:0] cu, cv, cw;
   } demand_word_type;

   typedef struct {
      logic [15:0] du, dv, dw;
      logic [1:0]  top;
   } duty_word_type;

   // Predicts duty counts and checks them in order
   class duty_scoreboard;
      duty_word_type pending_duty[$];
      int         mismatches;
      longint     sine_lut[0:1023];
      logic [15:0] gain, centre;
      logic        mode, dt_en;
      logic [14:0] threshold;
      logic [7:0]  dt_counts;

      function new();
         longint unsigned x, x2, term;
         longint sum, r;
         int q;
         q = 256;
         for (int k = 0; k <= q; k++) begin
            x = (64'd1686629713 * longint'(k)) / q;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 5; n++) begin
               term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
               if (n % 2 == 1) sum -= longint'(term);
               else sum += longint'(term);
            end
            if (sum < 0) sum = 0;
            r = (sum * 16384 + (longint'(1) << 29)) >>> 30;
            if (r > 16384) r = 16384;
            sine_lut[k] = r;
            sine_lut[2 * q - k] = r;
            if (k < q) sine_lut[2 * q + k] = -r;
            if (k > 0) sine_lut[1024 - k] = -r;
         end
         gain = 256; centre = 0; mode = 0; threshold = 0; dt_counts = 0; dt_en = 0;
         mismatches = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] data);
         case (idx)
            CSR_PWM_GAIN:        gain = data;
            CSR_PWM_CENTRE:      centre = data;
            CSR_MODULATION_MODE: mode = data[0];
            CSR_SINE_THRESHOLD:  threshold = data[14:0];
            CSR_DEADTIME_COUNTS: dt_counts = data[7:0];
            CSR_DEADTIME_ENABLE: dt_en = data[0];
            default: ;
         endcase
      endfunction

      function longint clip(longint c);
         if (c < 0) return 0;
         if (c > DUTY_MAX) return DUTY_MAX;
         return c;
      endfunction

      function void note_demand(demand_word_type w);
         longint vd, vq, sn, cs, a, b, h, top, bot, x, g;
         longint ph[3], cnt[3], cur[3];
         int idx;
         logic below, midpoint;
         phase_type top_idx;
         duty_word_type r;
         vd = longint'($signed(w.vd)) + longint'($signed(w.vdo));
         vq = longint'($signed(w.vq)) + longint'($signed(w.vqo));
         cur[0] = $signed(w.cu); cur[1] = $signed(w.cv); cur[2] = $signed(w.cw);
         idx = w.angle >> 6;
         sn = sine_lut[idx];
         cs = sine_lut[(idx + 256) % 1024];
         a = (cs * vd - sn * vq + 128) >>> 8;
         b = (sn * vd + cs * vq + 128) >>> 8;
         h = a * -32768;
         ph[0] = a * 65536;
         ph[1] = h + 56756 * b;
         ph[2] = h - 56756 * b;
         top = ph[0]; bot = ph[0]; top_idx = PHASE_U;
         if (ph[1] > top) begin top = ph[1]; top_idx = PHASE_V; end
         if (ph[2] > top) begin top = ph[2]; top_idx = PHASE_W; end
         if (ph[1] < bot) bot = ph[1];
         if (ph[2] < bot) bot = ph[2];
         below = w.mag < threshold;
         if (below) top_idx = PHASE_NONE;
         midpoint = !mode || below;
         g = gain;
         for (int i = 0; i < 3; i++) begin
            if (midpoint) begin
               x = longint'(centre) * (longint'(1) << 39) + g * (2 * ph[i] - top - bot);
               cnt[i] = (x < 0) ? 0 : clip(x >>> 39);
            end else begin
               x = g * (ph[i] - bot);
               cnt[i] = (x < 0) ? 0 : clip(x >>> 38);
            end
            if (!mode && dt_en) begin
               if (cur[i] < -30) cnt[i] = clip(cnt[i] - longint'(dt_counts));
               else if (cur[i] > -30) cnt[i] = clip(cnt[i] + longint'(dt_counts));
            end
         end
         r.du = 16'(cnt[0]); r.dv = 16'(cnt[1]); r.dw = 16'(cnt[2]); r.top = top_idx;
         pending_duty.push_back(r);
      endfunction

      function void check_duty(duty_word_type got);
         duty_word_type exp_w;
         if (pending_duty.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", got);
            return;
         end
         exp_w = pending_duty.pop_front();
         if (got != exp_w) begin
            mismatches++;
            if (mismatches <= 10) $display("duty mismatch: expected %p got %p", exp_w, got);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0, busy;
   logic [15:0] req_vd_demand = 0, req_vq_demand = 0, req_vd_offset = 0, req_vq_offset = 0;
   logic [15:0] req_rotor_angle = 0, req_current_u = 0, req_current_v = 0, req_current_w = 0;
   logic [14:0] req_voltage_magnitude = 0;
   logic rsp_valid;
   logic [15:0] rsp_duty_u, rsp_duty_v, rsp_duty_w;
   logic [1:0] rsp_top_phase;
   logic csr_write_enable = 0;
   logic [2:0] csr_index = 0;
   logic [15:0] csr_write_data = 0;

   duty_scoreboard sb = new();
   int idle_cycles = 0;

   foc_svpwm_modulator dut (.*);

   initial forever #5 clock = ~clock;

   // Sample accepted words and results at the rising edge
   always @(posedge clock) begin
      duty_word_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got.du = rsp_duty_u; got.dv = rsp_duty_v; got.dw = rsp_duty_w;
            got.top = rsp_top_phase;
            sb.check_duty(got);
         end
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 20000) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [15:0] data);
      @(negedge clock);
      csr_write_enable <= 1; csr_index <= idx; csr_write_data <= data;
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   // Drive one word and hold until taken
   task automatic send_demand(demand_word_type w);
      req_vd_demand <= w.vd; req_vq_demand <= w.vq;
      req_vd_offset <= w.vdo; req_vq_offset <= w.vqo;
      req_rotor_angle <= w.angle; req_voltage_magnitude <= w.mag;
      req_current_u <= w.cu; req_current_v <= w.cv; req_current_w <= w.cw;
      start <= 1;
      do @(posedge clock); while (busy);
      sb.note_demand(w);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(-30 + $urandom_range(0, 2) - 1);
         3: return 16'($urandom_range(0, 400)) - 16'd200;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic demand_word_type rand_demand();
      demand_word_type w;
      w.vd = pick16(); w.vq = pick16(); w.vdo = pick16(); w.vqo = pick16();
      if ($urandom_range(0, 2) == 0) begin
         w.vd = 16'($urandom_range(0, 2047)) - 16'd1024;
         w.vq = 16'($urandom_range(0, 2047)) - 16'd1024;
         w.vdo = 0; w.vqo = 0;
      end
      w.angle = 16'($urandom);
      w.mag = 15'($urandom);
      w.cu = pick16(); w.cv = pick16(); w.cw = pick16();
      return w;
   endfunction

   // Run n random words in bursts with random gaps
   task automatic random_phase(int n);
      int sent, burst;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst && sent < n; i++, sent++) send_demand(rand_demand());
         if ($urandom_range(0, 3) != 0) begin
            start <= 0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
      start <= 0;
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      while (sb.pending_duty.size() != 0 && waited < 5000) begin
         @(negedge clock); waited++;
      end
      repeat (PIPE_DEPTH + 4) @(negedge clock);
   endtask

   initial begin
      demand_word_type w;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: field extremes, angle corners, current around -30 mA
      write_reg(CSR_DEADTIME_COUNTS, 16'd255);
      write_reg(CSR_DEADTIME_ENABLE, 16'd1);
      write_reg(CSR_PWM_CENTRE, 16'd32768);
      for (int k = 0; k < 20; k++) begin
         w.vd = (k % 2) ? 16'h7fff : 16'h8000;
         w.vq = (k % 3 == 0) ? 16'h7fff : (k % 3 == 1) ? 16'h8000 : 16'h0000;
         w.vdo = (k % 4 < 2) ? 16'h7fff : 16'h8000;
         w.vqo = (k % 5 < 2) ? 16'h8000 : 16'h0100;
         w.angle = (k < 8) ? 16'(k * 16'h2000) : 16'(k * 16'h1234) | 16'hffc0;
         w.mag = (k % 2) ? 15'h7fff : 15'h0;
         w.cu = 16'(-31 + (k % 3)); w.cv = (k % 2) ? 16'h7fff : 16'h8000;
         w.cw = 16'(-30);
         if (k >= 16) begin w.vd = 0; w.vq = 0; w.vdo = 0; w.vqo = 0; end
         send_demand(w);
      end
      start <= 0;
      drain();

      // Sweep settings, extremes included
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin write_reg(CSR_PWM_GAIN, 16'hffff); write_reg(CSR_PWM_CENTRE, 16'hffff); end
            1: begin write_reg(CSR_PWM_GAIN, 16'd0); write_reg(CSR_PWM_CENTRE, 16'd0); end
            2: begin
               write_reg(CSR_MODULATION_MODE, 16'd1);
               write_reg(CSR_SINE_THRESHOLD, 16'h4000);
               write_reg(CSR_PWM_GAIN, 16'd256);
            end
            3: begin
               write_reg(CSR_SINE_THRESHOLD, 16'h7fff);
               write_reg(CSR_PWM_GAIN, 16'($urandom));
            end
            4: begin
               write_reg(CSR_MODULATION_MODE, 16'd0);
               write_reg(CSR_DEADTIME_COUNTS, 16'($urandom_range(0, 255)));
               write_reg(CSR_PWM_CENTRE, 16'($urandom));
               write_reg(CSR_SINE_THRESHOLD, 16'd0);
            end
            default: begin
               write_reg(CSR_DEADTIME_ENABLE, 16'd0);
               write_reg(CSR_DEADTIME_COUNTS, 16'd0);
               write_reg(CSR_PWM_GAIN, 16'd256);
            end
         endcase
         random_phase(205);
         drain();
      end

      if (sb.mismatches == 0 && sb.pending_duty.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
